// File: src/ieds_pkg.sv
package ieds_pkg;

  localparam int unsigned DefTimeWidth  = 48;
  localparam int unsigned DefCountWidth = 16;

  // Configuration register indexes.
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CfgIntervalLength   = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgEventsPerInterval = 1'b1;

  localparam int unsigned ActionWidth = 2;

  typedef enum logic [ActionWidth-1:0] {
    ActEnable  = 2'd0,
    ActFire    = 2'd1,
    ActDisable = 2'd2
  } action_e;

endpackage

// File: src/ieds_if.sv
interface ieds_in_if #(
  parameter int unsigned TimeWidth = ieds_pkg::DefTimeWidth
);
  logic                                valid;
  logic                                ready;
  logic [ieds_pkg::ActionWidth-1:0]    action;
  logic [TimeWidth-1:0]                now_time;

  modport source (output valid, output action, output now_time, input ready);
  modport sink   (input valid, input action, input now_time, output ready);
endinterface

interface ieds_out_if #(
  parameter int unsigned TimeWidth = ieds_pkg::DefTimeWidth
);
  logic                 valid;
  logic                 ready;
  logic                 fired;
  logic [TimeWidth-1:0] fired_time;
  logic [TimeWidth-1:0] next_deadline;
  logic                 armed;

  modport source (output valid, output fired, output fired_time, output next_deadline,
                  output armed, input ready);
  modport sink   (input valid, input fired, input fired_time, input next_deadline,
                  input armed, output ready);
endinterface

interface ieds_cfg_if #(
  parameter int unsigned TimeWidth = ieds_pkg::DefTimeWidth
);
  logic                               valid;
  logic                               ready;
  logic [ieds_pkg::CfgIdxWidth-1:0]   index;
  logic [TimeWidth-1:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/interval_event_deadline_scheduler_core.sv
// Channel   Dir   Payload                                        Beat when
// in_i      in    action, now_time                               valid & ready
// out_o     out   fired, fired_time, next_deadline, armed        valid & ready
// cfg_i     in    index, data                                    valid & ready
//
// An item that computes a deadline runs a shift-add multiply, a restoring divide of the
// product, and one add, all through the single shared adder.
// Reset clears the configuration and the scheduler state; in_i.ready is high in idle.
// The next item is taken while a result waits in the output register; a finished
// item holds in its last step until that register is free.
module interval_event_deadline_scheduler_core #(
  parameter int unsigned TIME_WIDTH  = ieds_pkg::DefTimeWidth,
  parameter int unsigned COUNT_WIDTH = ieds_pkg::DefCountWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ieds_in_if.sink      in_i,
  ieds_out_if.source   out_o,
  ieds_cfg_if.sink     cfg_i
);
  import ieds_pkg::*;

  localparam int unsigned ProdWidth = TIME_WIDTH + COUNT_WIDTH;
  localparam int unsigned StepWidth = $clog2(ProdWidth + 1);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StMul    = 5'b00010,
    StDiv    = 5'b00100,
    StAdd    = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [TIME_WIDTH-1:0]  len_q;
  logic [COUNT_WIDTH-1:0] evn_q;
  logic [TIME_WIDTH-1:0]  start_q, start_d;
  logic [COUNT_WIDTH-1:0] idx_q, idx_d;
  logic [TIME_WIDTH-1:0]  deadline_q, deadline_d;
  logic                   armed_q, armed_d;
  logic                   fired_q, fired_d;
  logic [TIME_WIDTH-1:0]  ftime_q, ftime_d;
  logic [ProdWidth-1:0]   acc_q, acc_d;
  logic [COUNT_WIDTH-1:0] mplr_q, mplr_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic [StepWidth-1:0]   step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic                   o_fired_q;
  logic [TIME_WIDTH-1:0]  o_ftime_q;
  logic [TIME_WIDTH-1:0]  o_next_q;
  logic                   o_armed_q;
  logic                   out_load;

  logic [ProdWidth-1:0]   alu_a, alu_b, alu_sum;
  logic                   alu_sub, alu_carry;
  logic [COUNT_WIDTH:0]   idx_inc;
  logic [COUNT_WIDTH:0]   rem_shift;
  logic                   in_beat;

  ieds_alu #(.Width(ProdWidth)) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign in_beat     = in_i.valid && in_i.ready;
  assign idx_inc     = {1'b0, idx_q} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign rem_shift   = {rem_q, acc_q[ProdWidth-1]};

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      StIdle: begin
        alu_a = {{COUNT_WIDTH{1'b0}}, start_q};
        alu_b = {{COUNT_WIDTH{1'b0}}, len_q};
      end
      StMul: begin
        alu_a = {acc_q[ProdWidth-2:0], 1'b0};
        alu_b = mplr_q[COUNT_WIDTH-1] ? {{COUNT_WIDTH{1'b0}}, len_q} : '0;
      end
      StDiv: begin
        alu_a   = {{(TIME_WIDTH-1){1'b0}}, rem_shift};
        alu_b   = {{TIME_WIDTH{1'b0}}, evn_q};
        alu_sub = 1'b1;
      end
      StAdd: begin
        // With zero events the quotient counts as zero.
        alu_a = {{COUNT_WIDTH{1'b0}}, start_q};
        alu_b = (evn_q == '0) ? '0 : {{COUNT_WIDTH{1'b0}}, acc_q[TIME_WIDTH-1:0]};
      end
      default: begin
        alu_a = acc_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    idx_d       = idx_q;
    deadline_d  = deadline_q;
    armed_d     = armed_q;
    fired_d     = fired_q;
    ftime_d     = ftime_q;
    acc_d       = acc_q;
    mplr_d      = mplr_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_beat) begin
          fired_d = 1'b0;
          ftime_d = '0;
          state_d = StFinish;
          case (in_i.action)
            ActEnable: begin
              if (evn_q != '0) begin
                start_d = in_i.now_time;
                idx_d   = '0;
                armed_d = 1'b1;
                state_d = StMul;
              end
            end
            ActFire: begin
              if (armed_q) begin
                fired_d = 1'b1;
                ftime_d = deadline_q;
                if (idx_inc >= {1'b0, evn_q}) begin
                  idx_d   = '0;
                  start_d = alu_sum[TIME_WIDTH-1:0];
                end else begin
                  idx_d = idx_inc[COUNT_WIDTH-1:0];
                end
                state_d = StMul;
              end
            end
            ActDisable: begin
              armed_d = 1'b0;
            end
            default: begin
              state_d = StFinish;
            end
          endcase
          mplr_d = idx_d + COUNT_WIDTH'(1);
          acc_d  = '0;
          step_d = '0;
        end
      end
      StMul: begin
        acc_d  = alu_sum;
        mplr_d = {mplr_q[COUNT_WIDTH-2:0], 1'b0};
        step_d = step_q + StepWidth'(1);
        if (step_q == StepWidth'(COUNT_WIDTH - 1)) begin
          step_d  = '0;
          rem_d   = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        // The remainder stays below the divisor, so it fits in COUNT_WIDTH bits.
        rem_d  = alu_carry ? alu_sum[COUNT_WIDTH-1:0] : rem_shift[COUNT_WIDTH-1:0];
        acc_d  = {acc_q[ProdWidth-2:0], alu_carry};
        step_d = step_q + StepWidth'(1);
        if (step_q == StepWidth'(ProdWidth - 1)) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        deadline_d = alu_sum[TIME_WIDTH-1:0];
        state_d    = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      evn_q       <= '0;
      start_q     <= '0;
      idx_q       <= '0;
      deadline_q  <= '0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      idx_q       <= idx_d;
      deadline_q  <= deadline_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CfgIntervalLength:    len_q <= cfg_i.data;
          CfgEventsPerInterval: evn_q <= cfg_i.data[COUNT_WIDTH-1:0];
          default:              len_q <= len_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fired_q <= fired_d;
    ftime_q <= ftime_d;
    acc_q   <= acc_d;
    mplr_q  <= mplr_d;
    rem_q   <= rem_d;
    step_q  <= step_d;
    if (out_load) begin
      o_fired_q <= fired_q;
      o_ftime_q <= ftime_q;
      o_next_q  <= armed_q ? deadline_q : '0;
      o_armed_q <= armed_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fired         = o_fired_q;
  assign out_o.fired_time    = o_ftime_q;
  assign out_o.next_deadline = o_next_q;
  assign out_o.armed         = o_armed_q;

endmodule

// File: src/ieds_alu.sv
module ieds_alu #(
  parameter int unsigned Width = ieds_pkg::DefTimeWidth + ieds_pkg::DefCountWidth
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  input  logic             sub_i,
  output logic [Width-1:0] sum_o,
  output logic             carry_o
);

  // Subtraction is a + ~b + 1; a carry out then means no borrow.
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_i ^ {Width{sub_i}}}
                          + {{Width{1'b0}}, sub_i};

endmodule

// File: src/ieds_checker.sv
module ieds_checker #(
  parameter int unsigned TimeWidth = ieds_pkg::DefTimeWidth
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 out_fired_i,
  input logic [TimeWidth-1:0] out_fired_time_i,
  input logic [TimeWidth-1:0] out_next_deadline_i,
  input logic                 out_armed_i
);

  // Only one item is in flight: input is closed the cycle after a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while an item is in progress");

  // A disarmed result reports no deadline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_armed_i) |-> (out_next_deadline_i == '0))
    else $error("next deadline nonzero while disarmed");

  // A result without an event carries a zero event time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_fired_i) |-> (out_fired_time_i == '0))
    else $error("fired time nonzero without an event");

  // Any event leaves the scheduler armed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_fired_i) |-> out_armed_i)
    else $error("event reported while disarmed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output beat dropped before it was taken");

endmodule

bind interval_event_deadline_scheduler_core ieds_checker #(
  .TimeWidth(TIME_WIDTH)
) u_ieds_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_fired_i        (out_o.fired),
  .out_fired_time_i   (out_o.fired_time),
  .out_next_deadline_i(out_o.next_deadline),
  .out_armed_i        (out_o.armed)
);

// File: test/interval_event_deadline_scheduler_core_tb.sv
`timescale 1ns / 1ps

module interval_event_deadline_scheduler_core_tb;
  import ieds_pkg::*;

  localparam int unsigned TW = DefTimeWidth;
  localparam int unsigned CW = DefCountWidth;
  localparam logic [ActionWidth-1:0] ActUnused = 2'd3;
  localparam logic [TW-1:0] TimeMax  = '1;
  localparam logic [CW-1:0] CountMax = '1;
  // Longest item in the block plus some slack for a stray late beat.
  localparam int unsigned DrainCycles = 2 * CW + TW + 3 + 40;

  typedef struct packed {
    logic          fired;
    logic [TW-1:0] fired_time;
    logic [TW-1:0] next_deadline;
    logic          armed;
  } sched_result_t;

  logic clk_i;
  logic rst_ni;

  ieds_in_if  #(.TimeWidth(TW)) in_if ();
  ieds_out_if #(.TimeWidth(TW)) out_if ();
  ieds_cfg_if #(.TimeWidth(TW)) cfg_if ();

  interval_event_deadline_scheduler_core #(
    .TIME_WIDTH (TW),
    .COUNT_WIDTH(CW)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Scheduler shadow state and configuration.
  logic [TW-1:0] interval_len   = '0;
  logic [CW-1:0] events_per_ivl = '0;
  logic [TW-1:0] ivl_start      = '0;
  logic [CW-1:0] event_idx      = '0;
  logic [TW-1:0] due_time       = '0;
  logic          sched_armed    = 1'b0;

  sched_result_t sched_result_q[$];
  int unsigned   mismatches  = 0;
  bit            src_gaps    = 1'b1;
  bit            sink_stalls = 1'b1;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // The scaled offset is taken at full precision before wrapping into the time width.
  function automatic logic [TW-1:0] deadline_after(logic [TW-1:0] start, logic [CW:0] k);
    logic [127:0] wide_len;
    logic [127:0] wide_k;
    logic [127:0] offset;
    if (events_per_ivl == '0) begin
      return start;
    end
    wide_len = 128'(interval_len);
    wide_k   = 128'(k);
    offset   = (wide_len * wide_k) / 128'(events_per_ivl);
    return start + offset[TW-1:0];
  endfunction

  function automatic sched_result_t predict_schedule(logic [ActionWidth-1:0] act,
                                                     logic [TW-1:0] now);
    sched_result_t res;
    logic [CW:0]   next_idx;
    res = '0;
    case (act)
      ActEnable: begin
        if (events_per_ivl != '0) begin
          ivl_start   = now;
          event_idx   = '0;
          sched_armed = 1'b1;
          due_time    = deadline_after(now, (CW+1)'(1));
        end
      end
      ActFire: begin
        if (sched_armed) begin
          res.fired      = 1'b1;
          res.fired_time = due_time;
          next_idx       = {1'b0, event_idx} + (CW+1)'(1);
          if (next_idx >= {1'b0, events_per_ivl}) begin
            next_idx  = '0;
            ivl_start = ivl_start + interval_len;
          end
          event_idx = next_idx[CW-1:0];
          due_time  = deadline_after(ivl_start, {1'b0, event_idx} + (CW+1)'(1));
        end
      end
      ActDisable: begin
        sched_armed = 1'b0;
      end
      default: ;
    endcase
    res.armed         = sched_armed;
    res.next_deadline = sched_armed ? due_time : '0;
    return res;
  endfunction

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[TW-1:0];
  endfunction

  function automatic void check_field(string name, logic [TW-1:0] want, logic [TW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sched_result_q.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, expected none, actual %h",
                 $time, {out_if.fired, out_if.fired_time, out_if.next_deadline, out_if.armed});
        mismatches++;
      end else begin
        want = sched_result_q.pop_front();
        check_field("fired", TW'(want.fired), TW'(out_if.fired));
        check_field("fired_time", want.fired_time, out_if.fired_time);
        check_field("next_deadline", want.next_deadline, out_if.next_deadline);
        check_field("armed", TW'(want.armed), TW'(out_if.armed));
      end
    end
  end

  // Result side back-pressure.
  initial begin : drive_result_ready
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_stalls && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 7);
        repeat (stall) begin
          out_if.ready <= 1'b0;
          @(negedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [ActionWidth-1:0] act, input logic [TW-1:0] now);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.now_time <= now;
    do @(posedge clk_i); while (!in_if.ready);
    sched_result_q.push_back(predict_schedule(act, now));
  endtask

  task automatic wait_drained(input int unsigned settle);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sched_result_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [TW-1:0] data);
    wait_drained(4);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CfgIntervalLength) begin
      interval_len = data;
    end else begin
      events_per_ivl = data[CW-1:0];
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // The events register only keeps its low bits, so the upper data bits carry noise.
  task automatic set_schedule(input logic [TW-1:0] len, input logic [CW-1:0] evn,
                              input bit noisy);
    logic [TW-1:0] evn_word;
    evn_word = noisy ? rand_time() : '0;
    evn_word[CW-1:0] = evn;
    write_reg(CfgIntervalLength, len);
    write_reg(CfgEventsPerInterval, evn_word);
  endtask

  task automatic test_reset_defaults();
    send_item(ActFire, '0);
    send_item(ActEnable, TimeMax);
    send_item(ActDisable, rand_time());
    send_item(ActUnused, rand_time());
    send_item(ActEnable, '0);
  endtask

  task automatic test_directed_corners();
    // One event per interval of maximum length, starting at the top of time.
    set_schedule(TimeMax, CW'(1), 1'b0);
    send_item(ActEnable, TimeMax);
    send_item(ActFire, '0);
    send_item(ActFire, '0);
    send_item(ActUnused, TimeMax);
    send_item(ActEnable, '0);
    // Largest product of length and count.
    set_schedule(TimeMax, CountMax, 1'b0);
    send_item(ActEnable, rand_time());
    repeat (3) send_item(ActFire, rand_time());
    // Lower the event count below the current index while armed.
    write_reg(CfgEventsPerInterval, TW'(2));
    repeat (2) send_item(ActFire, '0);
    // Zero events while armed: enable is refused, fires step whole intervals.
    write_reg(CfgEventsPerInterval, '0);
    send_item(ActEnable, rand_time());
    repeat (2) send_item(ActFire, '0);
    // Zero interval length.
    set_schedule('0, CW'(3), 1'b0);
    send_item(ActEnable, rand_time());
    repeat (3) send_item(ActFire, '0);
    send_item(ActDisable, '0);
    send_item(ActFire, TimeMax);
  endtask

  task automatic run_random_items(input int unsigned count);
    logic [ActionWidth-1:0] act;
    int unsigned            pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      // Mostly enable when disarmed and fire when armed, so intervals roll over.
      if (!sched_armed) begin
        act = (pick < 70) ? ActEnable : (pick < 85) ? ActFire :
              (pick < 93) ? ActDisable : ActUnused;
      end else begin
        act = (pick < 75) ? ActFire : (pick < 87) ? ActEnable :
              (pick < 95) ? ActDisable : ActUnused;
      end
      send_item(act, rand_time());
    end
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_schedule(TimeMax, CountMax, 1'b1);
        1: set_schedule('0, CW'(1), 1'b1);
        2: set_schedule(rand_time(), CW'($urandom_range(0, 65535)), 1'b1);
        3: set_schedule(TW'($urandom_range(1, 1000)), CW'($urandom_range(1, 6)), 1'b1);
        4: set_schedule(rand_time(), '0, 1'b1);
        5: set_schedule(TimeMax, CW'(1), 1'b1);
        6: set_schedule(rand_time(), CW'($urandom_range(1, 4)), 1'b1);
        default: set_schedule(rand_time(), CW'($urandom_range(0, 65535)), 1'b1);
      endcase
      run_random_items(60);
    end
  endtask

  task automatic test_full_rate();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    set_schedule(rand_time(), CW'($urandom_range(1, 8)), 1'b1);
    run_random_items(100);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.action   = ActEnable;
    in_if.now_time = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CfgIntervalLength;
    cfg_if.data    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed_corners();
    test_random_settings();
    test_full_rate();

    wait_drained(DrainCycles);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
